// ===== rtl/core/sfms_pkg.sv =====
`timescale 1ns / 1ps
package sfms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int BIN_W    = 9;
    localparam int AMP_W    = 25;
    localparam logic [AMP_W-1:0] AMP_MAX = 25'd16777216;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } t_pair;

    typedef struct packed {
        logic  valid;
        t_pair pair;
    } t_qhead;

endpackage

// ===== rtl/core/sfms_front.sv =====
`timescale 1ns / 1ps
module sfms_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [15:0]              i_left_sample,
    input  logic signed [15:0]              i_right_sample,
    input  logic                            i_in_range,
    input  logic                            i_pop,
    output logic                            o_busy,
    output sfms_pkg::t_qhead                o_head
);
    import sfms_pkg::*;

    t_pair      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_pair      pair_in;

    assign o_busy = r_cnt[1];
    assign push   = i_start && !r_cnt[1];
    assign pop    = i_pop && (r_cnt != 2'd0);

    // out-of-range pairs become zero padding
    always_comb begin
        pair_in.left  = i_in_range ? i_left_sample  : '0;
        pair_in.right = i_in_range ? i_right_sample : '0;
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.pair  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= pair_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/core/sfms_back.sv =====
`timescale 1ns / 1ps
module sfms_back #(
    parameter int FFT_POINTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfms_pkg::t_qhead     i_head,
    output logic                 o_pop,
    output logic                 o_result_valid,
    output logic [8:0]           o_bin_index,
    output logic [24:0]          o_amplitude,
    output logic                 o_last_bin
);
    import sfms_pkg::*;

    localparam int L       = $clog2(FFT_POINTS);
    localparam int HALF    = FFT_POINTS / 2;
    localparam int QUARTER = FFT_POINTS / 4;
    localparam int EIGHTH  = FFT_POINTS / 8;
    localparam int D       = L + 18;
    localparam int RW      = D + 8;
    localparam int SW      = $clog2(L);
    localparam int CW      = $clog2(RW);
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30    = 64'd1073741824;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BRD   = 4'd1;
    localparam logic [3:0] ST_BML   = 4'd2;
    localparam logic [3:0] ST_BMR   = 4'd3;
    localparam logic [3:0] ST_BTR   = 4'd4;
    localparam logic [3:0] ST_BWA   = 4'd5;
    localparam logic [3:0] ST_BWB   = 4'd6;
    localparam logic [3:0] ST_MRD   = 4'd7;
    localparam logic [3:0] ST_MSQ   = 4'd8;
    localparam logic [3:0] ST_MSUM  = 4'd9;
    localparam logic [3:0] ST_MSQRT = 4'd10;
    localparam logic [3:0] ST_MACC  = 4'd11;

    typedef logic [31:0] t_twtab [HALF];

    typedef struct packed {
        logic signed [D-1:0] lre;
        logic signed [D-1:0] lim;
        logic signed [D-1:0] rre;
        logic signed [D-1:0] rim;
    } t_word;

    function automatic logic [15:0] q30_to_q15(longint unsigned v);
        longint unsigned rr;
        rr = (v + 64'd16384) >> 15;
        return (rr > 64'd32767) ? 16'd32767 : rr[15:0];
    endfunction

    // Taylor term divisor k*(k+1)
    function automatic longint unsigned taylor_div(longint unsigned v, int k);
        case (k)
            1:       return v / 64'd2;
            2:       return v / 64'd6;
            3:       return v / 64'd12;
            4:       return v / 64'd20;
            5:       return v / 64'd30;
            6:       return v / 64'd42;
            7:       return v / 64'd56;
            8:       return v / 64'd72;
            9:       return v / 64'd90;
            default: return v / 64'd110;
        endcase
    endfunction

    // Q15 twiddles from a fixed-point Taylor series over one octant
    function automatic t_twtab build_tw();
        t_twtab          tab;
        longint unsigned x, x2, ts, tc, cq, sq, r;
        longint          s, c;
        int              q;
        logic [15:0]     c0, s0;
        for (int m = 0; m < HALF; m++) begin
            q = m / QUARTER;
            r = longint'(m % QUARTER);
            if (r > longint'(EIGHTH)) begin
                x = (longint'(QUARTER) - r) * TWO_PI_Q30 / FFT_POINTS;
            end else begin
                x = r * TWO_PI_Q30 / FFT_POINTS;
            end
            x2 = (x * x) >> 30;
            ts = x;
            tc = ONE_Q30;
            s  = longint'(x);
            c  = longint'(ONE_Q30);
            for (int n = 1; n <= 5; n++) begin
                ts = taylor_div((ts * x2) >> 30, 2 * n);
                tc = taylor_div((tc * x2) >> 30, 2 * n - 1);
                if (n % 2 == 1) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            cq = (s < 0) ? 64'd0 : longint'(c);
            sq = (s < 0) ? 64'd0 : longint'(s);
            if (c < 0) begin
                cq = 64'd0;
            end
            if (r > longint'(EIGHTH)) begin
                c0 = q30_to_q15(sq);
                s0 = q30_to_q15(cq);
            end else begin
                c0 = q30_to_q15(cq);
                s0 = q30_to_q15(sq);
            end
            if (q == 0) begin
                tab[m] = {c0, s0};
            end else begin
                tab[m] = {16'(-s0), c0};
            end
        end
        return tab;
    endfunction

    localparam t_twtab TW_TAB = build_tw();

    t_word               r_mem  [FFT_POINTS];
    logic [AMP_W-1:0]    r_spec [HALF];

    logic [3:0]          r_state;
    logic [L-1:0]        r_pos;
    logic                r_ready;
    logic [L-2:0]        r_k;
    logic [SW-1:0]       r_s;
    logic [L-2:0]        r_bin;
    logic [CW-1:0]       r_cnt;
    t_word               r_da;
    t_word               r_db;
    logic [31:0]         r_tw;
    logic signed [D+15:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [D+1:0] r_tl_re, r_tl_im, r_tr_re, r_tr_im;
    logic [2*D-1:0]      r_sqa  [2];
    logic [2*D-1:0]      r_sqb  [2];
    logic [2*RW-1:0]     r_rad  [2];
    logic [RW+1:0]       r_rem  [2];
    logic [RW-1:0]       r_root [2];
    logic                r_out_v;
    logic [BIN_W-1:0]    r_out_idx;
    logic                r_out_last;
    logic [AMP_W-1:0]    r_spec_q;

    logic                pop;
    logic                emit;
    logic [L-1:0]        rev_pos;
    logic [L-1:0]        kx;
    logic [L-1:0]        lowm;
    logic [L-1:0]        addr_a;
    logic [L-1:0]        addr_b;
    logic [L-2:0]        jj;
    logic [L-2:0]        tw_idx;
    logic                rd_en;
    logic [L-1:0]        rd_a;
    logic                wr_en;
    logic [L-1:0]        wr_addr;
    t_word               wr_data;
    logic signed [D-1:0] mb_re, mb_im;
    logic signed [15:0]  tw_c, tw_s;
    logic signed [D+15:0] m0, m1, m2, m3;
    logic signed [D+16:0] acc_re, acc_im;
    logic signed [D+1:0] t_re, t_im;
    logic signed [2*D-1:0] sq_re [2];
    logic signed [2*D-1:0] sq_im [2];
    logic [RW+1:0]       n_rem  [2];
    logic [RW-1:0]       n_root [2];
    logic [RW+1:0]       amp_sum;
    logic [RW+1:0]       amp_sh;
    logic [AMP_W-1:0]    amp;
    logic                spec_we;

    assign pop   = (r_state == ST_IDLE) && i_head.valid;
    assign o_pop = pop;
    assign emit  = r_ready && !r_pos[L-1];

    always_comb begin
        for (int b = 0; b < L; b++) begin
            rev_pos[b] = r_pos[L-1-b];
        end
    end

    // butterfly addressing for stage r_s, butterfly r_k
    always_comb begin
        kx     = {1'b0, r_k};
        lowm   = (L'(1) << r_s) - L'(1);
        addr_a = ((kx & ~lowm) << 1) | (kx & lowm);
        addr_b = addr_a | (L'(1) << r_s);
        jj     = (L-1)'(kx & lowm);
        tw_idx = jj << (SW'(L - 1) - r_s);
    end

    always_comb begin
        rd_en = 1'b0;
        rd_a  = addr_a;
        if (r_state == ST_BRD) begin
            rd_en = 1'b1;
        end else if (r_state == ST_MRD) begin
            rd_en = 1'b1;
            rd_a  = {1'b0, r_bin};
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rev_pos;
        wr_data.lre = D'(i_head.pair.left);
        wr_data.lim = '0;
        wr_data.rre = D'(i_head.pair.right);
        wr_data.rim = '0;
        case (r_state)
            ST_IDLE: begin
                wr_en = pop;
            end
            ST_BWA: begin
                wr_en   = 1'b1;
                wr_addr = addr_a;
                wr_data.lre = D'((D+2)'(r_da.lre) + r_tl_re);
                wr_data.lim = D'((D+2)'(r_da.lim) + r_tl_im);
                wr_data.rre = D'((D+2)'(r_da.rre) + r_tr_re);
                wr_data.rim = D'((D+2)'(r_da.rim) + r_tr_im);
            end
            ST_BWB: begin
                wr_en   = 1'b1;
                wr_addr = addr_b;
                wr_data.lre = D'((D+2)'(r_da.lre) - r_tl_re);
                wr_data.lim = D'((D+2)'(r_da.lim) - r_tl_im);
                wr_data.rre = D'((D+2)'(r_da.rre) - r_tr_re);
                wr_data.rim = D'((D+2)'(r_da.rim) - r_tr_im);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_da <= r_mem[rd_a];
            r_db <= r_mem[addr_b];
            r_tw <= TW_TAB[tw_idx];
        end
    end

    // complex multiply, one channel per cycle
    always_comb begin
        mb_re = (r_state == ST_BML) ? r_db.lre : r_db.rre;
        mb_im = (r_state == ST_BML) ? r_db.lim : r_db.rim;
        tw_c  = signed'(r_tw[31:16]);
        tw_s  = signed'(r_tw[15:0]);
        m0    = mb_re * tw_c;
        m1    = mb_im * tw_s;
        m2    = mb_im * tw_c;
        m3    = mb_re * tw_s;
        acc_re = (D+17)'(r_p0) + (D+17)'(r_p1) + (D+17)'(16384);
        acc_im = (D+17)'(r_p2) - (D+17)'(r_p3) + (D+17)'(16384);
        t_re   = (D+2)'(acc_re >>> 15);
        t_im   = (D+2)'(acc_im >>> 15);
    end

    // squares and one root bit per cycle, both channels in parallel
    always_comb begin
        sq_re[0] = r_da.lre * r_da.lre;
        sq_im[0] = r_da.lim * r_da.lim;
        sq_re[1] = r_da.rre * r_da.rre;
        sq_im[1] = r_da.rim * r_da.rim;
        for (int c = 0; c < 2; c++) begin
            logic [RW+1:0] rem_sh;
            logic [RW+1:0] trial;
            rem_sh = {r_rem[c][RW-1:0], r_rad[c][2*RW-1 -: 2]};
            trial  = {r_root[c], 2'b01};
            if (rem_sh >= trial) begin
                n_rem[c]  = rem_sh - trial;
                n_root[c] = {r_root[c][RW-2:0], 1'b1};
            end else begin
                n_rem[c]  = rem_sh;
                n_root[c] = {r_root[c][RW-2:0], 1'b0};
            end
        end
        amp_sum = (RW+2)'(r_root[0]) + (RW+2)'(r_root[1]) + (RW+2)'(HALF);
        amp_sh  = amp_sum >> L;
        amp     = (amp_sh > (RW+2)'(AMP_MAX)) ? AMP_MAX : AMP_W'(amp_sh);
        spec_we = (r_state == ST_MACC);
    end

    always_ff @(posedge i_clk) begin
        if (spec_we) begin
            r_spec[r_bin] <= amp;
        end
        if (pop) begin
            r_spec_q <= r_spec[r_pos[L-2:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_BML: begin
                r_p0 <= m0;
                r_p1 <= m1;
                r_p2 <= m2;
                r_p3 <= m3;
            end
            ST_BMR: begin
                r_p0    <= m0;
                r_p1    <= m1;
                r_p2    <= m2;
                r_p3    <= m3;
                r_tl_re <= t_re;
                r_tl_im <= t_im;
            end
            ST_BTR: begin
                r_tr_re <= t_re;
                r_tr_im <= t_im;
            end
            ST_MSQ: begin
                for (int c = 0; c < 2; c++) begin
                    r_sqa[c] <= (2*D)'(unsigned'(sq_re[c]));
                    r_sqb[c] <= (2*D)'(unsigned'(sq_im[c]));
                end
            end
            ST_MSUM: begin
                for (int c = 0; c < 2; c++) begin
                    r_rad[c]  <= {r_sqa[c] + r_sqb[c], 16'd0};
                    r_rem[c]  <= '0;
                    r_root[c] <= '0;
                end
            end
            ST_MSQRT: begin
                for (int c = 0; c < 2; c++) begin
                    r_rad[c]  <= r_rad[c] << 2;
                    r_rem[c]  <= n_rem[c];
                    r_root[c] <= n_root[c];
                end
            end
            default: begin
                r_p0 <= r_p0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_idx <= BIN_W'(r_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pos      <= '0;
            r_ready    <= 1'b0;
            r_k        <= '0;
            r_s        <= '0;
            r_bin      <= '0;
            r_cnt      <= '0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_out_v    <= pop && emit;
            r_out_last <= pop && emit && (r_pos == L'(HALF - 1));
            case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        if (emit && (r_pos == L'(HALF - 1))) begin
                            r_ready <= 1'b0;
                        end
                        r_pos <= r_pos + L'(1);
                        if (r_pos == {L{1'b1}}) begin
                            r_k     <= '0;
                            r_s     <= '0;
                            r_state <= ST_BRD;
                        end
                    end
                end
                ST_BRD: r_state <= ST_BML;
                ST_BML: r_state <= ST_BMR;
                ST_BMR: r_state <= ST_BTR;
                ST_BTR: r_state <= ST_BWA;
                ST_BWA: r_state <= ST_BWB;
                ST_BWB: begin
                    if (r_k == (L-1)'(HALF - 1)) begin
                        r_k <= '0;
                        if (r_s == SW'(L - 1)) begin
                            r_bin   <= '0;
                            r_state <= ST_MRD;
                        end else begin
                            r_s     <= r_s + SW'(1);
                            r_state <= ST_BRD;
                        end
                    end else begin
                        r_k     <= r_k + (L-1)'(1);
                        r_state <= ST_BRD;
                    end
                end
                ST_MRD:  r_state <= ST_MSQ;
                ST_MSQ:  r_state <= ST_MSUM;
                ST_MSUM: begin
                    r_cnt   <= '0;
                    r_state <= ST_MSQRT;
                end
                ST_MSQRT: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(RW - 1)) begin
                        r_state <= ST_MACC;
                    end
                end
                ST_MACC: begin
                    if (r_bin == (L-1)'(HALF - 1)) begin
                        r_ready <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_bin   <= r_bin + (L-1)'(1);
                        r_state <= ST_MRD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_result_valid = r_out_v;
    assign o_bin_index    = r_out_idx;
    assign o_amplitude    = r_spec_q;
    assign o_last_bin     = r_out_last;

`ifndef SYNTHESIS
    a_emit_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> $past(r_state) == ST_IDLE)
        else $error("result strobe without a popped beat");
    a_last_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_last |-> r_out_v)
        else $error("last bin flag without strobe");
    a_fft_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BRD && $past(r_state) == ST_IDLE) |-> $past(r_pos) == {L{1'b1}})
        else $error("transform started before frame end");
    a_ready_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_last |-> !r_ready)
        else $error("spectrum still marked ready after last bin");
`endif

endmodule

// ===== rtl/core/stereo_fft_magnitude_spectrum_core.sv =====
`timescale 1ns / 1ps
// Stereo magnitude spectrum. Sample pairs are accepted on start while busy is low and
// are collected in frames of FFT_POINTS. After the last pair of a frame the block runs
// a radix-2 FFT on both channels with one shared butterfly datapath and then a
// bit-serial square root pass over the N/2 bins; busy rises once the two-beat input
// queue fills during that time. Bin k of the previous frame's spectrum is strobed on
// o_result_valid in the cycle after the queued beat at frame position k is taken in,
// for positions below N/2; the receiver cannot stall and must take each result in the
// cycle it is shown. A frame of zero padding flushes the last spectrum.
module stereo_fft_magnitude_spectrum_core #(
    parameter int FFT_POINTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_left_sample,
    input  logic signed [15:0] i_right_sample,
    input  logic               i_in_range,
    output logic               o_result_valid,
    output logic [8:0]         o_bin_index,
    output logic [24:0]        o_amplitude,
    output logic               o_last_bin
);
    import sfms_pkg::*;

    t_qhead head;
    logic   pop;

    sfms_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_in_range     (i_in_range),
        .i_pop          (pop),
        .o_busy         (busy),
        .o_head         (head)
    );

    sfms_back #(
        .FFT_POINTS (FFT_POINTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_bin_index    (o_bin_index),
        .o_amplitude    (o_amplitude),
        .o_last_bin     (o_last_bin)
    );

endmodule

// ===== dv/tb_stereo_fft_magnitude_spectrum_core.sv =====
`timescale 1ns / 1ps
module tb_stereo_fft_magnitude_spectrum_core;
    import sfms_pkg::*;

    localparam int N        = 1024;
    localparam int HALF     = N / 2;
    localparam int LOG2N    = $clog2(N);
    localparam int RAND_LEN = 400;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30    = 64'd1073741824;
    localparam int WATCHDOG = 400000;

    typedef struct {
        logic [BIN_W-1:0] bin;
        logic [AMP_W-1:0] amp;
        logic             last;
    } t_bin_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_left_sample = '0;
    logic signed [15:0] i_right_sample = '0;
    logic               i_in_range = 1'b0;
    logic               o_result_valid;
    logic [8:0]         o_bin_index;
    logic [24:0]        o_amplitude;
    logic               o_last_bin;

    stereo_fft_magnitude_spectrum_core #(.FFT_POINTS(N)) u_dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    longint     tw_c[HALF];
    longint     tw_s[HALF];
    t_pair      pair_mem[N];
    logic [AMP_W-1:0] spec_mem[HALF];
    int         frame_pos;
    bit         spec_valid;
    longint     fre_l[N], fim_l[N], fre_r[N], fim_r[N];
    t_bin_beat  bin_q[$];

    int errors, beats_in, bins_seen, frames_done, clamped, idle_cycles;

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic void octant_trig(input longint unsigned x,
                                        output longint unsigned cq,
                                        output longint unsigned sq);
        longint unsigned x2, ts, tc;
        longint s, c;
        x2 = (x * x) >> 30;
        ts = x;
        tc = ONE_Q30;
        s = longint'(x);
        c = longint'(ONE_Q30);
        for (int n = 1; n <= 5; n++) begin
            ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n & 1) begin
                s -= longint'(ts);
                c -= longint'(tc);
            end else begin
                s += longint'(ts);
                c += longint'(tc);
            end
        end
        cq = s < 0 ? 0 : longint'(c);
        sq = s < 0 ? 0 : longint'(s);
        if (c < 0) cq = 0;
    endfunction

    function automatic longint to_q15(input longint unsigned v);
        longint unsigned r;
        r = (v + 16384) >> 15;
        return r > 32767 ? 32767 : longint'(r);
    endfunction

    function automatic void build_twiddles();
        longint unsigned cq, sq;
        longint c0, s0;
        int q, r;
        for (int m = 0; m < HALF; m++) begin
            q = m / (N / 4);
            r = m % (N / 4);
            if (r > N / 8) begin
                octant_trig(longint'(N / 4 - r) * TWO_PI_Q30 / N, cq, sq);
                c0 = to_q15(sq);
                s0 = to_q15(cq);
            end else begin
                octant_trig(longint'(r) * TWO_PI_Q30 / N, cq, sq);
                c0 = to_q15(cq);
                s0 = to_q15(sq);
            end
            if (q == 0) begin
                tw_c[m] = c0;
                tw_s[m] = s0;
            end else begin
                tw_c[m] = -s0;
                tw_s[m] = c0;
            end
        end
    endfunction

    function automatic void fft_radix2(ref longint re[N], ref longint im[N]);
        int rv, half, stride, a, b, w;
        longint t, tr, ti;
        for (int i = 0; i < N; i++) begin
            rv = 0;
            for (int k = 0; k < LOG2N; k++) rv |= ((i >> k) & 1) << (LOG2N - 1 - k);
            if (rv > i) begin
                t = re[i]; re[i] = re[rv]; re[rv] = t;
                t = im[i]; im[i] = im[rv]; im[rv] = t;
            end
        end
        for (int len = 2; len <= N; len <<= 1) begin
            half = len >> 1;
            stride = N / len;
            for (int i = 0; i < N; i += len) begin
                for (int j = 0; j < half; j++) begin
                    a = i + j;
                    b = a + half;
                    w = (j * stride) & (HALF - 1);
                    tr = (re[b] * tw_c[w] + im[b] * tw_s[w] + 16384) >>> 15;
                    ti = (im[b] * tw_c[w] - re[b] * tw_s[w] + 16384) >>> 15;
                    re[b] = re[a] - tr;
                    im[b] = im[a] - ti;
                    re[a] += tr;
                    im[a] += ti;
                end
            end
        end
    endfunction

    function automatic longint unsigned mag_q8(input longint re, input longint im);
        longint unsigned v, rem, root, pr, trial;
        v = longint'(re < 0 ? -re : re) ** 2 + longint'(im < 0 ? -im : im) ** 2;
        rem = 0;
        root = 0;
        for (int i = 39; i >= 0; i--) begin
            pr = i >= 8 ? (v >> (2 * (i - 8))) & 3 : 0;
            trial = (root << 2) | 1;
            rem = (rem << 2) | pr;
            root <<= 1;
            if (rem >= trial) begin
                rem -= trial;
                root |= 1;
            end
        end
        return root;
    endfunction

    function automatic void compute_spectrum();
        longint unsigned sum, amp;
        for (int i = 0; i < N; i++) begin
            fre_l[i] = pair_mem[i].left;
            fre_r[i] = pair_mem[i].right;
            fim_l[i] = 0;
            fim_r[i] = 0;
        end
        fft_radix2(fre_l, fim_l);
        fft_radix2(fre_r, fim_r);
        for (int i = 0; i < HALF; i++) begin
            sum = mag_q8(fre_l[i], fim_l[i]) + mag_q8(fre_r[i], fim_r[i]);
            amp = (sum + N / 2) / N;
            if (amp > AMP_MAX) begin
                amp = AMP_MAX;
                clamped++;
            end
            spec_mem[i] = amp[AMP_W-1:0];
        end
        frames_done++;
    endfunction

    function automatic void predict_pair(input logic signed [15:0] l,
                                         input logic signed [15:0] r, input logic ir);
        t_bin_beat e;
        if (spec_valid && frame_pos < HALF) begin
            e.bin  = frame_pos[BIN_W-1:0];
            e.amp  = spec_mem[frame_pos];
            e.last = frame_pos == HALF - 1;
            bin_q  = {bin_q, e};
            if (e.last) spec_valid = 1'b0;
        end
        pair_mem[frame_pos] = ir ? t_pair'({r, l}) : '0;
        frame_pos++;
        if (frame_pos >= N) begin
            compute_spectrum();
            spec_valid = 1'b1;
            frame_pos = 0;
        end
    endfunction

    // monitor: check results, then predict accepted beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (o_result_valid) begin
                idle_cycles = 0;
                bins_seen++;
                if (bin_q.size() == 0) begin
                    report($sformatf("unexpected bin %0d", o_bin_index));
                end else begin
                    t_bin_beat e;
                    e = bin_q.pop_front();
                    if (o_bin_index !== e.bin)
                        report($sformatf("bin_index %0d exp %0d", o_bin_index, e.bin));
                    if (o_amplitude !== e.amp)
                        report($sformatf("bin %0d amplitude %0d exp %0d",
                                         e.bin, o_amplitude, e.amp));
                    if (o_last_bin !== e.last)
                        report($sformatf("bin %0d last_bin %0b exp %0b",
                                         e.bin, o_last_bin, e.last));
                end
            end
            if (start && !busy) begin
                idle_cycles = 0;
                beats_in++;
                predict_pair(i_left_sample, i_right_sample, i_in_range);
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("Watchdog expired, %0d bins outstanding", bin_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r,
                             input logic ir, input bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_left_sample  <= l;
        i_right_sample <= r;
        i_in_range     <= ir;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // field extremes and out-of-range pairs, then random content
    task automatic test_extremes_and_random();
        logic signed [15:0] ext[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
        for (int i = 0; i < 16; i++) send_pair(ext[i % 4], ext[i / 4], 1'b1, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
        send_pair(16'sh8000, 16'sh7fff, 1'b0, 1'b0);
        send_pair(16'shffff, 16'shffff, 1'b0, 1'b0);
        for (int i = 19; i < RAND_LEN; i++) begin
            send_pair(16'($urandom), 16'($urandom), $urandom_range(0, 9) != 0,
                      (i / 64) % 3 != 0);
        end
    endtask

    // rest of the frame at full-scale negative on both channels, near the amplitude clamp
    task automatic test_fullscale_run();
        for (int i = RAND_LEN; i < N; i++) send_pair(16'sh8000, 16'sh8000, 1'b1, i % 8 != 0);
    endtask

    // out-of-range padding flushes the previous frame's spectrum
    task automatic test_padding_flush();
        for (int i = 0; i < HALF; i++) send_pair(16'($urandom), 16'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        errors = 0; beats_in = 0; bins_seen = 0; frames_done = 0;
        clamped = 0; idle_cycles = 0;
        frame_pos = 0;
        spec_valid = 1'b0;
        build_twiddles();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes_and_random();
        test_fullscale_run();
        test_padding_flush();
        start <= 1'b0;
        while (bin_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d sample pairs over %0d completed frames; checked %0d bins",
                 beats_in, frames_done, bins_seen);
        $display("Bins at the amplitude clamp: %0d", clamped);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sfms_pkg.sv
rtl/core/sfms_front.sv
rtl/core/sfms_back.sv
rtl/core/stereo_fft_magnitude_spectrum_core.sv
dv/tb_stereo_fft_magnitude_spectrum_core.sv
